@@ hw/rtl/rqmtf_pkg.sv @@
package rqmtf_pkg;

	// sizes of the identifier space
	localparam int MAX_PEOPLE = 256;
	localparam int ID_W       = 9;
	localparam int ADDR_W     = $clog2(MAX_PEOPLE);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_PEOPLE);

	// request kinds as carried in the func field
	typedef enum logic {
		OP_SERVE    = 1'b0,
		OP_EXPEDITE = 1'b1
	} op_e_t;

	typedef struct packed {
		op_e_t           op;
		logic [ID_W-1:0] id;
	} req_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		B_IDLE,
		B_SERVE,
		B_EXPED
	} back_state_t;

	// circular successor of a slot within the current population
	function automatic logic [ADDR_W-1:0] next_slot(
		input logic [ADDR_W-1:0] slot,
		input logic [ID_W-1:0]   pop
	);
		logic [ID_W-1:0] inc;
		inc = ID_W'(slot) + ID_W'(1);
		if (inc == pop) begin
			return '0;
		end else begin
			return inc[ADDR_W-1:0];
		end
	endfunction

endpackage

@@ hw/rtl/rqmtf_front.sv @@
module rqmtf_front (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [rqmtf_pkg::ID_W-1:0] citizen_id,
	input  logic [rqmtf_pkg::ID_W-1:0] pop,
	input  logic                       q_full,
	output logic                       push,
	output rqmtf_pkg::req_t            push_req
);
	import rqmtf_pkg::*;

	logic in_range;

	// expedites of unknown identifiers are taken and dropped here
	assign in_range = (citizen_id != '0) && (citizen_id <= pop);
	assign in_stall = q_full;

	always_comb begin
		push_req.op = (func == 1'b1) ? OP_EXPEDITE : OP_SERVE;
		push_req.id = citizen_id;
		push        = in_valid && !q_full && ((push_req.op == OP_SERVE) || in_range);
	end

endmodule

@@ hw/rtl/rqmtf_queue.sv @@
module rqmtf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rqmtf_pkg::req_t push_req,
	output logic            full,
	input  logic            pop,
	output logic            q_valid,
	output rqmtf_pkg::req_t q_req
);
	import rqmtf_pkg::*;

	req_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_req   = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_req;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

@@ hw/rtl/rqmtf_back.sv @@
module rqmtf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       reload,
	input  logic [rqmtf_pkg::ID_W-1:0] pop,
	input  logic                       q_valid,
	input  rqmtf_pkg::req_t            q_req,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rqmtf_pkg::ID_W-1:0] served_id
);
	import rqmtf_pkg::*;

	logic [ID_W-1:0]       mem [MAX_PEOPLE];
	logic [MAX_PEOPLE-1:0] written_q;
	logic [ID_W-1:0]       rd_data_q;
	logic                  rd_written_q;
	logic [ADDR_W-1:0]     rd_addr_q;

	back_state_t       state_q, state_d;
	logic [ADDR_W-1:0] head_q, head_d;
	logic [ID_W-1:0]   carry_q, carry_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic              out_valid_q, out_valid_d;
	logic [ID_W-1:0]   served_q, served_d;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ID_W-1:0]   wr_data;
	logic [ID_W-1:0]   entry;

	assign out_valid = out_valid_q;
	assign served_id = served_q;

	// an entry never written since reload holds its own slot number plus one
	assign entry = rd_written_q ? rd_data_q : (ID_W'(rd_addr_q) + ID_W'(1));

	// order memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q    <= mem[rd_addr];
			rd_written_q <= written_q[rd_addr];
			rd_addr_q    <= rd_addr;
		end
	end

	// written flags, cleared at once by reset or reload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (reload) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= reload ? '0 : head_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		carry_q  <= carry_d;
		id_q     <= id_d;
		served_q <= served_d;
	end

	// sequencer: serve reads the head, expedite walks from the head
	// rotating each entry back by one until the identifier is met
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		carry_d     = carry_q;
		id_d        = id_q;
		served_d    = served_q;
		out_valid_d = out_valid_q && out_stall;
		q_pop       = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = head_q;
		wr_en       = 1'b0;
		wr_addr     = rd_addr_q;
		wr_data     = carry_q;
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					rd_en   = 1'b1;
					id_d    = q_req.id;
					carry_d = q_req.id;
					state_d = (q_req.op == OP_EXPEDITE) ? B_EXPED : B_SERVE;
				end
			end
			B_SERVE: begin
				if (!(out_valid_q && out_stall)) begin
					out_valid_d = 1'b1;
					served_d    = entry;
					head_d      = next_slot(head_q, pop);
					state_d     = B_IDLE;
				end
			end
			B_EXPED: begin
				wr_en   = 1'b1;
				carry_d = entry;
				if (entry == id_q) begin
					state_d = B_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = next_slot(rd_addr_q, pop);
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/rotating_queue_move_to_front_unit.sv @@
// channel   | handshake               | payload
// ----------+-------------------------+-------------------
// request   | in_valid / in_stall     | func, citizen_id
// result    | out_valid / out_stall   | served_id
// config    | cfg_valid / cfg_ready   | population
//
// a serve transaction in the sequencer is one memory read, then one result load
// an expedite walks the order memory from the head to the identifier (distance at most 255),
// using the single read port, which steps one slot a cycle
// a two-entry request queue lets new transactions enter while the sequencer works
// reset gives order 1..256 with head at zero; no clearing pass, written flags do it
// a stalled result holds the sequencer only on the next serve, not on expedites
module rotating_queue_move_to_front_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [rqmtf_pkg::ID_W-1:0] citizen_id,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rqmtf_pkg::ID_W-1:0] served_id,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rqmtf_pkg::ID_W-1:0] population
);
	import rqmtf_pkg::*;

	logic [ID_W-1:0] pop_q;
	logic            reload;
	logic            q_full;
	logic            push;
	req_t            push_req;
	logic            q_pop;
	logic            q_valid;
	req_t            q_req;

	assign cfg_ready = 1'b1;
	assign reload    = cfg_valid && cfg_ready;

	// population register, clamped to 1..MAX_PEOPLE
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= MAX_ID;
		end else if (reload) begin
			priority if (population == '0) begin
				pop_q <= ID_W'(1);
			end else if (population > MAX_ID) begin
				pop_q <= MAX_ID;
			end else begin
				pop_q <= population;
			end
		end
	end

	rqmtf_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.citizen_id (citizen_id),
		.pop        (pop_q),
		.q_full     (q_full),
		.push       (push),
		.push_req   (push_req)
	);

	rqmtf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_req    (q_req)
	);

	rqmtf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.reload    (reload),
		.pop       (pop_q),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.served_id (served_id)
	);

endmodule
